### src/assert_macros.svh
// Assertion macros shared by the interrupt dispatch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define IDH_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### src/idh_pkg.sv
// Types, constants and helpers for the interrupt dispatch block.
package idh_pkg;

  localparam int SrcW  = 5;
  localparam int AddrW = 16;
  localparam int ByteW = 8;
  localparam int VecW  = 7;

  localparam logic [VecW-1:0] VecNone   = 7'h00;
  localparam logic [VecW-1:0] VecVblank = 7'h40;
  localparam logic [VecW-1:0] VecLcd    = 7'h48;
  localparam logic [VecW-1:0] VecTimer  = 7'h50;
  localparam logic [VecW-1:0] VecSerial = 7'h58;
  localparam logic [VecW-1:0] VecJoypad = 7'h60;

  typedef struct packed {
    logic [SrcW-1:0]  raise_bits;
    logic [AddrW-1:0] current_pc;
    logic [AddrW-1:0] stack_pointer;
    logic             enter_halt;
    logic             ime_scheduled;
    logic             is_ei_or_di;
  } item_t;

  typedef struct packed {
    logic             taken;
    logic [VecW-1:0]  vector;
    logic [AddrW-1:0] new_stack_pointer;
    logic [ByteW-1:0] push_high;
    logic [ByteW-1:0] push_low;
    logic             halted;
    logic             master_enable;
    logic [SrcW-1:0]  pending_out;
  } result_t;

  function automatic logic [VecW-1:0] vector_of(input logic [SrcW-1:0] req);
    if (req[0]) return VecVblank;
    else if (req[1]) return VecLcd;
    else if (req[2]) return VecTimer;
    else if (req[3]) return VecSerial;
    else if (req[4]) return VecJoypad;
    else return VecNone;
  endfunction

  function automatic logic [SrcW-1:0] lowest_bit(input logic [SrcW-1:0] req);
    logic [SrcW-1:0] neg;
    neg = ~req + SrcW'(1);
    return req & neg;
  endfunction

endpackage

### src/idh_item_if.sv
// Handshake channel carrying one instruction-boundary item.
interface idh_item_if;
  import idh_pkg::*;

  logic             valid;
  logic             ready;
  logic [SrcW-1:0]  raise_bits;
  logic [AddrW-1:0] current_pc;
  logic [AddrW-1:0] stack_pointer;
  logic             enter_halt;
  logic             ime_scheduled;
  logic             is_ei_or_di;

  modport source (
    output valid, raise_bits, current_pc, stack_pointer, enter_halt, ime_scheduled,
           is_ei_or_di,
    input  ready
  );

  modport sink (
    input  valid, raise_bits, current_pc, stack_pointer, enter_halt, ime_scheduled,
           is_ei_or_di,
    output ready
  );
endinterface

### src/idh_result_if.sv
// Handshake channel carrying one dispatch result.
interface idh_result_if;
  import idh_pkg::*;

  logic             valid;
  logic             ready;
  logic             taken;
  logic [VecW-1:0]  vector;
  logic [AddrW-1:0] new_stack_pointer;
  logic [ByteW-1:0] push_high;
  logic [ByteW-1:0] push_low;
  logic             halted;
  logic             master_enable;
  logic [SrcW-1:0]  pending_out;

  modport source (
    output valid, taken, vector, new_stack_pointer, push_high, push_low, halted,
           master_enable, pending_out,
    input  ready
  );

  modport sink (
    input  valid, taken, vector, new_stack_pointer, push_high, push_low, halted,
           master_enable, pending_out,
    output ready
  );
endinterface

### src/interrupt_dispatch_with_halt.sv
// Instruction-boundary interrupt controller with halt handling.
// Channels: items (sink) takes one item per instruction boundary with the
// newly raised request bits, PC, SP, HALT flag, scheduled master enable and
// EI/DI marker. results (source) gives one result per item: dispatch flag,
// vector, SP (decremented on dispatch), pushed PC bytes and the halt,
// master enable and pending state after the item. A transfer happens when
// valid and ready are both high at a rising edge.
// cfg_write_en/cfg_write_data write the five-bit interrupt enable mask; write
// it only while no item is in flight.
// Path: an item is captured in the input register, then goes through the
// dispatch logic into the result register, which presents the result.
// Throughput: one item per cycle while the receiver takes results; input
// register and result register each hold while the next stage is full, so
// the receiver may stall freely and items back up without loss.
// Reset (rst, synchronous): clears pending flags, master enable, halt flag,
// the enable mask and both stage valids.
module interrupt_dispatch_with_halt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [idh_pkg::SrcW-1:0] cfg_write_data,
  idh_item_if.sink                 items,
  idh_result_if.source             results
);
  import idh_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  idh_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  idh_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .results        (results)
  );
endmodule

### src/idh_in_reg.sv
// Input register stage: captures one item per transfer.
module idh_in_reg (
  input  logic          clk,
  input  logic          rst,
  idh_item_if.sink      items,
  output logic          item_valid,
  input  logic          item_ready,
  output idh_pkg::item_t item
);
  import idh_pkg::*;

  logic  held;
  item_t data;
  logic  take_in;

  assign items.ready = !held || item_ready;
  assign take_in     = items.valid && items.ready;
  assign item_valid  = held;
  assign item        = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take_in) begin
      held <= 1'b1;
    end else if (item_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      data.raise_bits    <= items.raise_bits;
      data.current_pc    <= items.current_pc;
      data.stack_pointer <= items.stack_pointer;
      data.enter_halt    <= items.enter_halt;
      data.ime_scheduled <= items.ime_scheduled;
      data.is_ei_or_di   <= items.is_ei_or_di;
    end
  end
endmodule

### src/idh_core.sv
// Dispatch logic: pending, master enable and halt state with the result register.
module idh_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [idh_pkg::SrcW-1:0]  cfg_write_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  idh_pkg::item_t            item,
  idh_result_if.source              results
);
  import idh_pkg::*;
  `include "assert_macros.svh"

  logic [SrcW-1:0] int_enable;
  logic [SrcW-1:0] pending;
  logic            ime;
  logic            halt;
  logic            res_valid;
  result_t         res;

  logic [SrcW-1:0] pend_raised;
  logic [SrcW-1:0] req_ready;
  logic [SrcW-1:0] pending_next;
  logic            ime_next;
  logic            halt_next;
  result_t         res_next;
  logic            load;

  assign item_ready = !res_valid || results.ready;
  assign load       = item_valid && item_ready;

  always_comb begin
    pend_raised  = pending | item.raise_bits;
    req_ready    = pend_raised & int_enable;
    pending_next = pend_raised;
    ime_next     = ime;
    halt_next    = halt;
    res_next.taken             = 1'b0;
    res_next.vector            = VecNone;
    res_next.new_stack_pointer = item.stack_pointer;
    res_next.push_high         = '0;
    res_next.push_low          = '0;
    if (halt) begin
      halt_next = (req_ready == '0);
    end else begin
      if (ime && (req_ready != '0)) begin
        res_next.taken             = 1'b1;
        res_next.vector            = vector_of(req_ready);
        res_next.new_stack_pointer = item.stack_pointer - AddrW'(2);
        res_next.push_high         = item.current_pc[AddrW-1:ByteW];
        res_next.push_low          = item.current_pc[ByteW-1:0];
        pending_next               = pend_raised & ~lowest_bit(req_ready);
        ime_next                   = 1'b0;
      end
      if (item.enter_halt) begin
        halt_next = 1'b1;
      end
      if (!item.is_ei_or_di) begin
        ime_next = item.ime_scheduled;
      end
    end
    res_next.halted        = halt_next;
    res_next.master_enable = ime_next;
    res_next.pending_out   = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable <= '0;
      pending    <= '0;
      ime        <= 1'b0;
      halt       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        int_enable <= cfg_write_data;
      end
      if (load) begin
        pending   <= pending_next;
        ime       <= ime_next;
        halt      <= halt_next;
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign results.valid             = res_valid;
  assign results.taken             = res.taken;
  assign results.vector            = res.vector;
  assign results.new_stack_pointer = res.new_stack_pointer;
  assign results.push_high         = res.push_high;
  assign results.push_low          = res.push_low;
  assign results.halted            = res.halted;
  assign results.master_enable     = res.master_enable;
  assign results.pending_out       = res.pending_out;

  `IDH_ASSERT_NEXT(a_state_matches_result, load,
    res.halted == halt && res.master_enable == ime && res.pending_out == pending,
    "result flags disagree with stored state")
  `IDH_ASSERT_NEXT(a_no_dispatch_halted, load && halt, !res.taken,
    "dispatch while halted")
  `IDH_ASSERT_NEXT(a_no_dispatch_masked, load && !ime, !res.taken,
    "dispatch with master enable clear")
  `IDH_ASSERT(a_taken_vector, !res_valid || (res.taken == (res.vector != VecNone)),
    "taken flag and vector disagree")
endmodule

### bench/interrupt_dispatch_with_halt_test.sv
// Self-checking testbench for the instruction-boundary interrupt dispatcher.
`timescale 1ns / 1ps

module interrupt_dispatch_with_halt_test;
  import idh_pkg::*;

  localparam int NumDirected = 23;
  localparam int RandomItems = 1650;
  localparam int CycleLimit  = 500000;
  localparam int Latency     = 4;
  localparam logic [VecW-1:0] SrcVectors [SrcW] =
    '{VecVblank, VecLcd, VecTimer, VecSerial, VecJoypad};

  typedef struct packed {
    logic            wr_mask;
    logic [SrcW-1:0] mask;
    item_t           stim;
    logic            has_result;
    result_t         result;
  } step_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [SrcW-1:0] cfg_write_data;

  idh_item_if   items_ch ();
  idh_result_if results_ch ();

  interrupt_dispatch_with_halt dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .items          (items_ch),
    .results        (results_ch)
  );

  logic [SrcW-1:0] enable_mask;
  logic [SrcW-1:0] pending_flags;
  logic            ime_flag;
  logic            halt_flag;

  result_t expected_dispatches [$];
  step_t   directed_steps [NumDirected];
  logic    row_has_result;
  result_t row_result;
  logic    quiet_phase;
  int      recv_hold;
  int      cycle_count;
  int      item_count;
  int      result_count;
  int      dispatch_count;
  int      wake_count;
  int      mask_writes;
  int      mismatch_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t predict_dispatch(input item_t it);
    result_t r;
    logic [SrcW-1:0] ready_bits;
    int n;
    r = '0;
    r.new_stack_pointer = it.stack_pointer;
    pending_flags = pending_flags | it.raise_bits;
    ready_bits = pending_flags & enable_mask;
    if (halt_flag) begin
      if (ready_bits != '0) begin
        halt_flag = 1'b0;
        wake_count++;
      end
    end else begin
      if (ime_flag && ready_bits != '0) begin
        n = 0;
        while (!ready_bits[n]) n++;
        r.taken = 1'b1;
        r.vector = SrcVectors[n];
        r.new_stack_pointer = it.stack_pointer - 16'd2;
        r.push_high = it.current_pc[15:8];
        r.push_low = it.current_pc[7:0];
        pending_flags[n] = 1'b0;
        ime_flag = 1'b0;
        dispatch_count++;
      end
      if (it.enter_halt) halt_flag = 1'b1;
      if (!it.is_ei_or_di) ime_flag = it.ime_scheduled;
    end
    r.halted = halt_flag;
    r.master_enable = ime_flag;
    r.pending_out = pending_flags;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      note_mismatch($sformatf("result %0d: %s expected 'h%0h, got 'h%0h",
                              result_count, name, want, got));
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding",
               expected_dispatches.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        it.raise_bits    = items_ch.raise_bits;
        it.current_pc    = items_ch.current_pc;
        it.stack_pointer = items_ch.stack_pointer;
        it.enter_halt    = items_ch.enter_halt;
        it.ime_scheduled = items_ch.ime_scheduled;
        it.is_ei_or_di   = items_ch.is_ei_or_di;
        want = predict_dispatch(it);
        expected_dispatches.push_back(row_has_result ? row_result : want);
      end
      if (results_ch.valid && results_ch.ready) begin
        if (expected_dispatches.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_count));
        end else begin
          want = expected_dispatches.pop_front();
          check_field("taken", 16'(want.taken), 16'(results_ch.taken));
          check_field("vector", 16'(want.vector), 16'(results_ch.vector));
          check_field("new_stack_pointer", want.new_stack_pointer,
                      results_ch.new_stack_pointer);
          check_field("push_high", 16'(want.push_high), 16'(results_ch.push_high));
          check_field("push_low", 16'(want.push_low), 16'(results_ch.push_low));
          check_field("halted", 16'(want.halted), 16'(results_ch.halted));
          check_field("master_enable", 16'(want.master_enable),
                      16'(results_ch.master_enable));
          check_field("pending_out", 16'(want.pending_out),
                      16'(results_ch.pending_out));
        end
        result_count++;
        recv_hold = quiet_phase ? 0 : $urandom_range(0, 8);
      end
    end
  end

  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        results_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input item_t it, input logic has_result,
                           input result_t res);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.raise_bits    <= it.raise_bits;
    items_ch.current_pc    <= it.current_pc;
    items_ch.stack_pointer <= it.stack_pointer;
    items_ch.enter_halt    <= it.enter_halt;
    items_ch.ime_scheduled <= it.ime_scheduled;
    items_ch.is_ei_or_di   <= it.is_ei_or_di;
    items_ch.valid         <= 1'b1;
    row_has_result         <= has_result;
    row_result             <= res;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    item_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    items_ch.valid <= 1'b0;
    while (expected_dispatches.size() != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
  endtask

  task automatic write_enable_mask(input logic [SrcW-1:0] mask);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mask;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    enable_mask = mask;
    mask_writes++;
  endtask

  function automatic logic [AddrW-1:0] random_addr();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    return AddrW'($urandom_range(0, 65535));
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.current_pc    = random_addr();
    it.stack_pointer = random_addr();
    if ($urandom_range(0, 7) == 0) begin
      it.raise_bits    = SrcW'($urandom_range(0, 31));
      it.enter_halt    = 1'($urandom_range(0, 1));
      it.ime_scheduled = 1'($urandom_range(0, 1));
      it.is_ei_or_di   = 1'($urandom_range(0, 1));
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: it.raise_bits = '0;
        10, 11, 12, 13, 14, 15, 16: it.raise_bits = SrcW'(1) << $urandom_range(0, 4);
        default: it.raise_bits = SrcW'($urandom_range(0, 31));
      endcase
      it.enter_halt    = ($urandom_range(0, 7) == 0);
      it.ime_scheduled = ($urandom_range(0, 4) != 0);
      it.is_ei_or_di   = ($urandom_range(0, 7) == 0);
    end
    return it;
  endfunction

  initial begin
    logic [SrcW-1:0] mask;
    int phase_len;
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    items_ch.valid <= 1'b0;
    items_ch.raise_bits    <= '0;
    items_ch.current_pc    <= '0;
    items_ch.stack_pointer <= '0;
    items_ch.enter_halt    <= 1'b0;
    items_ch.ime_scheduled <= 1'b0;
    items_ch.is_ei_or_di   <= 1'b0;
    row_has_result <= 1'b0;
    row_result     <= '0;
    quiet_phase = 1'b0;
    recv_hold = 0;
    enable_mask = '0;
    pending_flags = '0;
    ime_flag = 1'b0;
    halt_flag = 1'b0;

    // wr, mask | raise, pc, sp, halt, sched, ei/di | has result |
    // taken, vector, new sp, push high, push low, halted, master enable, pending
    directed_steps = '{
      {1'b0, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 5'h00},
      {1'b0, 5'h00, 5'h1f, 16'hffff, 16'hffff, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b0, 7'h00, 16'hffff, 8'h00, 8'h00, 1'b0, 1'b1, 5'h1f},
      {1'b1, 5'h1f, 5'h00, 16'hffff, 16'h0001, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b1, VecVblank, 16'hffff, 8'hff, 8'hff, 1'b0, 1'b1, 5'h1e},
      {1'b0, 5'h1f, 5'h00, 16'h1234, 16'h0000, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b1, VecLcd, 16'hfffe, 8'h12, 8'h34, 1'b0, 1'b1, 5'h1c},
      {1'b0, 5'h1f, 5'h00, 16'habcd, 16'h8000, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b1, VecTimer, 16'h7ffe, 8'hab, 8'hcd, 1'b0, 1'b1, 5'h18},
      {1'b0, 5'h1f, 5'h00, 16'h00ff, 16'h0002, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b1, VecSerial, 16'h0000, 8'h00, 8'hff, 1'b0, 1'b1, 5'h10},
      {1'b0, 5'h1f, 5'h00, 16'hff00, 16'hfffe, 1'b0, 1'b0, 1'b0,
       1'b1, 1'b1, VecJoypad, 16'hfffc, 8'hff, 8'h00, 1'b0, 1'b0, 5'h00},
      {1'b0, 5'h1f, 5'h1f, 16'h5555, 16'h5555, 1'b0, 1'b0, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h5555, 8'h00, 8'h00, 1'b0, 1'b0, 5'h1f},
      {1'b0, 5'h1f, 5'h00, 16'haaaa, 16'haaaa, 1'b0, 1'b1, 1'b1,
       1'b1, 1'b0, 7'h00, 16'haaaa, 8'h00, 8'h00, 1'b0, 1'b0, 5'h1f},
      {1'b0, 5'h1f, 5'h00, 16'h0000, 16'hffff, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b0, 7'h00, 16'hffff, 8'h00, 8'h00, 1'b0, 1'b1, 5'h1f},
      {1'b0, 5'h1f, 5'h00, 16'h0100, 16'hc000, 1'b1, 1'b1, 1'b0,
       1'b1, 1'b1, VecVblank, 16'hbffe, 8'h01, 8'h00, 1'b1, 1'b1, 5'h1e},
      {1'b0, 5'h1f, 5'h00, 16'h7777, 16'h1111, 1'b1, 1'b0, 1'b1,
       1'b1, 1'b0, 7'h00, 16'h1111, 8'h00, 8'h00, 1'b0, 1'b1, 5'h1e},
      {1'b1, 5'h00, 5'h00, 16'h8000, 16'h2222, 1'b1, 1'b0, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h2222, 8'h00, 8'h00, 1'b1, 1'b0, 5'h1e},
      {1'b0, 5'h00, 5'h01, 16'h4000, 16'h3333, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h3333, 8'h00, 8'h00, 1'b1, 1'b0, 5'h1f},
      {1'b1, 5'h08, 5'h00, 16'h4000, 16'h4444, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h4444, 8'h00, 8'h00, 1'b0, 1'b0, 5'h1f},
      {1'b0, 5'h08, 5'h00, 16'h4002, 16'h4444, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b0, 7'h00, 16'h4444, 8'h00, 8'h00, 1'b0, 1'b1, 5'h1f},
      {1'b0, 5'h08, 5'h00, 16'h2468, 16'h1357, 1'b0, 1'b1, 1'b0,
       1'b1, 1'b1, VecSerial, 16'h1355, 8'h24, 8'h68, 1'b0, 1'b1, 5'h17},
      {1'b1, 5'h14, 5'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
       1'b1, 1'b1, VecTimer, 16'hfffe, 8'h00, 8'h00, 1'b0, 1'b0, 5'h13},
      {1'b0, 5'h14, 5'h08, 16'hffff, 16'h0000, 1'b0, 1'b1, 1'b1,
       1'b1, 1'b0, 7'h00, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 5'h1b},
      {1'b1, 5'h1f, 5'h00, 16'h1000, 16'h2000, 1'b0, 1'b1, 1'b0,
       1'b0, 47'h0},
      {1'b0, 5'h1f, 5'h1f, 16'h3000, 16'h4000, 1'b1, 1'b1, 1'b0,
       1'b0, 47'h0},
      {1'b0, 5'h1f, 5'h00, 16'h5000, 16'h6000, 1'b0, 1'b0, 1'b1,
       1'b0, 47'h0},
      {1'b0, 5'h1f, 5'h04, 16'hfedc, 16'h0001, 1'b0, 1'b1, 1'b0,
       1'b0, 47'h0}
    };

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].wr_mask) write_enable_mask(directed_steps[i].mask);
      send_item(directed_steps[i].stim, directed_steps[i].has_result,
                directed_steps[i].result);
    end

    while (item_count < NumDirected + RandomItems) begin
      case ($urandom_range(0, 5))
        0: mask = '0;
        1: mask = '1;
        default: mask = SrcW'($urandom_range(0, 31));
      endcase
      quiet_phase = 1'b0;
      write_enable_mask(mask);
      quiet_phase = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) send_item(random_item(), 1'b0, '0);
    end

    quiet_phase = 1'b0;
    drain_results();

    $display("Covered %0d boundary transfers under %0d enable masks;", item_count,
             mask_writes);
    $display("%0d dispatches and %0d halt wake-ups were predicted and checked.",
             dispatch_count, wake_count);
    if (mismatch_count == 0 && expected_dispatches.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
